// ----- src/edns_pkg.sv -----
// ---------------------------------------------------------------------------
// edns_pkg: shared types and constants for the EDNS0 OPT record parser
// Item formats, result kinds, error codes and parser phases.
// ---------------------------------------------------------------------------
package edns_pkg;

  // longest owner name in bytes
  localparam logic [7:0] NAME_MAX = 8'd255;

  // resource record type of OPT
  localparam logic [15:0] TYPE_OPT = 16'd41;

  // reset value of the highest known option code
  localparam logic [15:0] HKC_RESET = 16'd18;

  // result kinds
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_OPT_HDR  = 3'd1;
  localparam logic [2:0] KIND_OPT_DATA = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NAME_LONG = 2'd0;
  localparam logic [1:0] ERR_BUF_END   = 2'd1;
  localparam logic [1:0] ERR_NOT_OPT   = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  // fixed header byte positions after the owner name
  localparam logic [3:0] FIX_TYPE_LO  = 4'd1;
  localparam logic [3:0] FIX_SIZE_LO  = 4'd3;
  localparam logic [3:0] FIX_RCODE    = 4'd4;
  localparam logic [3:0] FIX_VERSION  = 4'd5;
  localparam logic [3:0] FIX_FLAGS_HI = 4'd6;
  localparam logic [3:0] FIX_RDLEN_LO = 4'd9;

  // option header byte positions
  localparam logic [1:0] OPT_CODE_LO = 2'd1;
  localparam logic [1:0] OPT_LEN_LO  = 2'd3;

  // result queue depth
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NAME,
    PH_PTR,
    PH_FIXED,
    PH_OHDR,
    PH_ODATA,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] payload_size;
    logic [7:0]  ext_rcode;
    logic [7:0]  edns_version;
    logic        dnssec_ok;
    logic [15:0] rdata_length;
    logic [15:0] option_code;
    logic [15:0] option_length;
    logic [7:0]  option_byte;
    logic [15:0] consumed_count;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // results of one byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_push_t;

  // error result with every other field zero
  function automatic out_item_t mk_error(logic [1:0] code);
    out_item_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

// ----- src/edns0_opt_record_parser.sv -----
// ---------------------------------------------------------------------------
// edns0_opt_record_parser: EDNS0 OPT record parser
// Skips the owner name, checks the type, reports the OPT header and walks
// the option list, one record byte per transfer.
// ---------------------------------------------------------------------------
// Bytes are taken at one per cycle unless the input stalls: each byte is held
// in the input register, where the parse step runs, and its results (up to
// two) go into a four-entry result queue. The input stalls only while that
// queue holds more than two results, so bytes that give at most one result
// each stream without pause while the output side keeps taking them; each
// result is queued before it reaches the output. Configuration writes
// to highest_known_code take effect on the next byte parsed.
module edns0_opt_record_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  edns_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output edns_pkg::out_item_t out_data_o
);
  import edns_pkg::*;

  res_push_t push;
  logic      room;

  // byte parser
  edns_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .room_i      (room),
    .push_o      (push)
  );

  // result queue
  edns_rq u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/edns_parse.sv -----
// ---------------------------------------------------------------------------
// edns_parse: input register and per-byte record parser
// Holds one byte, runs the parse step on it and updates the record state.
// ---------------------------------------------------------------------------
module edns_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  edns_pkg::in_item_t  in_data_i,
  input  logic                room_i,
  output edns_pkg::res_push_t push_o
);
  import edns_pkg::*;

  logic        item_v_q, item_v_d;
  in_item_t    item_q;
  logic        proc;

  logic [15:0] hkc_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  nc_q, nc_d;
  logic [3:0]  fi_q, fi_d;
  logic [15:0] fs_q, fs_d;
  logic [15:0] pay_q, pay_d;
  logic [7:0]  ext_q, ext_d;
  logic [7:0]  ver_q, ver_d;
  logic        do_q, do_d;
  logic [15:0] rdlen_q, rdlen_d;
  logic [15:0] rp_q, rp_d;
  logic [15:0] cc_q, cc_d;
  logic [15:0] bl_q, bl_d;
  logic [15:0] tc_q, tc_d;
  logic        known_q, known_d;

  // input register: one byte held until the queue has room
  assign proc       = item_v_q && room_i;
  assign in_stall_o = item_v_q && !room_i;

  always_comb begin
    item_v_d = item_v_q;
    if (in_valid_i && !in_stall_o) begin
      item_v_d = 1'b1;
    end else if (proc) begin
      item_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else begin
      item_v_q <= item_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // parse step
  always_comb begin
    logic [7:0]  b;
    phase_e      ph;
    logic        complete;
    logic        prim_v;
    logic        fin_v;
    out_item_t   prim;
    out_item_t   fin;
    logic [16:0] left_before;
    logic [16:0] left_after;
    logic [8:0]  nc_ptr;

    b           = item_q.data_byte;
    ph          = phase_q;
    complete    = 1'b0;
    prim_v      = 1'b0;
    fin_v       = 1'b0;
    prim        = '0;
    fin         = '0;
    left_before = '0;
    left_after  = '0;
    nc_ptr      = '0;

    phase_d = phase_q;
    nc_d    = nc_q;
    fi_d    = fi_q;
    fs_d    = fs_q;
    pay_d   = pay_q;
    ext_d   = ext_q;
    ver_d   = ver_q;
    do_d    = do_q;
    rdlen_d = rdlen_q;
    rp_d    = rp_q;
    cc_d    = cc_q;
    bl_d    = bl_q;
    tc_d    = tc_q;
    known_d = known_q;

    if (proc) begin
      // record start clears all record state
      if (item_q.record_start) begin
        phase_d = PH_NAME;
        nc_d    = '0;
        fi_d    = '0;
        fs_d    = '0;
        pay_d   = '0;
        ext_d   = '0;
        ver_d   = '0;
        do_d    = 1'b0;
        rdlen_d = '0;
        rp_d    = '0;
        cc_d    = '0;
        bl_d    = '0;
        tc_d    = '0;
        known_d = 1'b0;
      end

      ph = phase_d;
      if (ph != PH_IDLE) begin
        tc_d = tc_d + 16'd1;

        unique case (ph)
          // owner name: labels, terminator or compression pointer
          PH_NAME: begin
            nc_ptr = {1'b0, nc_d} + 9'd2;
            if (b == 8'd0) begin
              phase_d = PH_FIXED;
              fi_d    = '0;
            end else if (b[7:6] == 2'b11) begin
              if (nc_ptr > {1'b0, NAME_MAX}) begin
                prim_v  = 1'b1;
                prim    = mk_error(ERR_NAME_LONG);
                phase_d = PH_IDLE;
              end else begin
                nc_d    = nc_ptr[7:0];
                phase_d = PH_PTR;
              end
            end else if (nc_d >= NAME_MAX) begin
              prim_v  = 1'b1;
              prim    = mk_error(ERR_NAME_LONG);
              phase_d = PH_IDLE;
            end else begin
              nc_d = nc_d + 8'd1;
            end
          end

          // second pointer byte
          PH_PTR: begin
            phase_d = PH_FIXED;
            fi_d    = '0;
          end

          // type, class, ttl and rdata length
          PH_FIXED: begin
            fs_d = {fs_d[7:0], b};
            case (fi_d)
              FIX_TYPE_LO: begin
                if (fs_d != TYPE_OPT) begin
                  prim_v  = 1'b1;
                  prim    = mk_error(ERR_NOT_OPT);
                  phase_d = PH_IDLE;
                end
              end
              FIX_SIZE_LO:  pay_d   = fs_d;
              FIX_RCODE:    ext_d   = b;
              FIX_VERSION:  ver_d   = b;
              FIX_FLAGS_HI: do_d    = b[7];
              FIX_RDLEN_LO: rdlen_d = fs_d;
              default: ;
            endcase
            if (phase_d != PH_IDLE) begin
              if (fi_d == FIX_RDLEN_LO) begin
                prim_v            = 1'b1;
                prim.kind         = KIND_HEADER;
                prim.payload_size = pay_d;
                prim.ext_rcode    = ext_d;
                prim.edns_version = ver_d;
                prim.dnssec_ok    = do_d;
                prim.rdata_length = rdlen_d;
                rp_d = '0;
                fi_d = '0;
                fs_d = '0;
                if (rdlen_d == 16'd0) begin
                  complete = 1'b1;
                end else begin
                  phase_d = PH_OHDR;
                end
              end else begin
                fi_d = fi_d + 4'd1;
              end
            end
          end

          // option walk over the rdata
          PH_OHDR, PH_ODATA, PH_SKIP: begin
            left_before = {1'b0, rdlen_q} - {1'b0, rp_q};
            rp_d        = rp_q + 16'd1;
            left_after  = {1'b0, rdlen_q} - {1'b0, rp_d};
            if (ph == PH_OHDR) begin
              if (fi_d == 4'd0 && !left_before[16] && left_before[15:0] < 16'd4) begin
                phase_d = PH_SKIP;
              end else begin
                fs_d = {fs_d[7:0], b};
                if (fi_d[1:0] == OPT_CODE_LO) begin
                  cc_d = fs_d;
                end
                if (fi_d[1:0] == OPT_LEN_LO) begin
                  bl_d = fs_d;
                  fi_d = '0;
                  fs_d = '0;
                  if (!left_after[16] && bl_d > left_after[15:0]) begin
                    prim_v  = 1'b1;
                    prim    = mk_error(ERR_OVERRUN);
                    phase_d = PH_SKIP;
                  end else begin
                    known_d = (cc_d >= 16'd1) && (cc_d <= hkc_q);
                    if (known_d) begin
                      prim_v             = 1'b1;
                      prim.kind          = KIND_OPT_HDR;
                      prim.option_code   = cc_d;
                      prim.option_length = bl_d;
                    end
                    phase_d = (bl_d == 16'd0) ? PH_OHDR : PH_ODATA;
                  end
                end else begin
                  fi_d = fi_d + 4'd1;
                end
              end
            end else if (ph == PH_ODATA) begin
              if (known_d) begin
                prim_v           = 1'b1;
                prim.kind        = KIND_OPT_DATA;
                prim.option_code = cc_d;
                prim.option_byte = b;
              end
              bl_d = bl_d - 16'd1;
              if (bl_d == 16'd0) begin
                phase_d = PH_OHDR;
                fi_d    = '0;
                fs_d    = '0;
              end
            end
            if (rp_d == rdlen_q) begin
              complete = 1'b1;
            end
          end

          default: ;
        endcase

        // record end or early buffer end
        if (phase_d != PH_IDLE) begin
          if (complete) begin
            fin_v              = 1'b1;
            fin.kind           = KIND_DONE;
            fin.consumed_count = tc_d;
            phase_d            = PH_IDLE;
          end else if (item_q.buffer_end) begin
            fin_v   = 1'b1;
            fin     = mk_error(ERR_BUF_END);
            phase_d = PH_IDLE;
          end
        end
      end
    end

    // mark the last result of this byte
    if (fin_v) begin
      fin.last_of_run = 1'b1;
    end else if (prim_v) begin
      prim.last_of_run = 1'b1;
    end

    push_o.count  = {1'b0, prim_v} + {1'b0, fin_v};
    push_o.first  = prim_v ? prim : fin;
    push_o.second = fin;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hkc_q <= HKC_RESET;
    end else if (cfg_we_i) begin
      hkc_q <= cfg_wdata_i;
    end
  end

  // record state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      nc_q    <= '0;
      fi_q    <= '0;
      fs_q    <= '0;
      pay_q   <= '0;
      ext_q   <= '0;
      ver_q   <= '0;
      do_q    <= 1'b0;
      rdlen_q <= '0;
      rp_q    <= '0;
      cc_q    <= '0;
      bl_q    <= '0;
      tc_q    <= '0;
      known_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      nc_q    <= nc_d;
      fi_q    <= fi_d;
      fs_q    <= fs_d;
      pay_q   <= pay_d;
      ext_q   <= ext_d;
      ver_q   <= ver_d;
      do_q    <= do_d;
      rdlen_q <= rdlen_d;
      rp_q    <= rp_d;
      cc_q    <= cc_d;
      bl_q    <= bl_d;
      tc_q    <= tc_d;
      known_q <= known_d;
    end
  end

endmodule

// ----- src/edns_rq.sv -----
// ---------------------------------------------------------------------------
// edns_rq: result queue
// Takes up to two results per cycle and delivers one per transfer.
// ---------------------------------------------------------------------------
module edns_rq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edns_pkg::res_push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output edns_pkg::out_item_t out_data_o
);
  import edns_pkg::*;

  out_item_t         mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0]  wp_q, wp_d;
  logic [RQ_AW-1:0]  rp_q, rp_d;
  logic [RQ_AW:0]    cnt_q, cnt_d;
  logic [RQ_AW-1:0]  wp_next;
  logic              pop;

  // room for the two results a byte can cause
  assign room_o      = cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rp_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wp_next     = wp_q + 1'b1;

  // pointer and fill level update
  always_comb begin
    wp_d  = wp_q + push_i.count[RQ_AW-1:0];
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (RQ_AW+1)'(push_i.count) - (RQ_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wp_next] <= push_i.second;
    end
  end

endmodule
